// ===== design/khdc_pkg.sv =====
// Shared types and constants of the k-mer index and diagonal hit counter.
`timescale 1ns / 1ps

package khdc_pkg;

   // Request command codes (req_tuser[1:0])
   localparam logic [1:0] CMD_REF   = 2'd0;
   localparam logic [1:0] CMD_READ  = 2'd1;
   localparam logic [1:0] CMD_COUNT = 2'd2;
   localparam logic [1:0] CMD_NONE  = 2'd3;

   // Head table entry kinds
   localparam logic [1:0] HEAD_EMPTY  = 2'd0;
   localparam logic [1:0] HEAD_START  = 2'd1;
   localparam logic [1:0] HEAD_REPEAT = 2'd2;

   // Configuration register indexes
   localparam logic [1:0] CSR_WINDOW_START = 2'd0;
   localparam logic [1:0] CSR_WINDOW_END   = 2'd1;
   localparam logic [1:0] CSR_MAX_REPEAT   = 2'd2;

   // Field widths
   localparam int CMD_W   = 2;
   localparam int BASE_W  = 8;
   localparam int POS_W   = 10;
   localparam int COUNT_W = 11;
   localparam int WSTART_W = 10;
   localparam int WEND_W   = 11;
   localparam int REPEAT_W = 7;
   localparam int SEEN_W   = 8;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   localparam logic [WSTART_W-1:0] WINDOW_START_RST = 10'd0;
   localparam logic [WEND_W-1:0]   WINDOW_END_RST   = 11'd1024;
   localparam logic [REPEAT_W-1:0] MAX_REPEAT_RST   = 7'd8;

   // Which memories a clearing sweep covers
   typedef struct packed {
      logic index;   // head table and links
      logic counts;  // hit counters
   } clr_sel_type;

endpackage

// ===== design/kmer_hash_index_diagonal_counter.sv =====
// Top level: k-mer chained index of a reference and per-diagonal hit counter.
`timescale 1ns / 1ps
//
//  channel | dir | handshake              | payload
//  req     | in  | req_tvalid/req_tready  | tuser: cmd, first; tdata: base, position
//  rsp     | out | rsp_tvalid/rsp_tready  | tdata: count
//  csr     | in  | csr_wr_en              | csr_index, csr_wdata
//
//  One request at a time. A base whose window is not yet full goes back to idle after
//  its step; else its head entry is read, and a reference base walks its chain (up to
//  max_repeat entries) to append its window, a read base to count diagonal hits. A count
//  readout waits while a response is held. A first flag starts a sweep over
//  max(4^KMER_SIZE, MAX_SEQ_LEN) entries; reset starts the same sweep over all memories,
//  with req_tready low throughout. The walk speed is set by the registered read of the link and count memories.

module kmer_hash_index_diagonal_counter #(
   parameter int KMER_SIZE   = 8,
   parameter int MAX_SEQ_LEN = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [2:0]  req_tuser,   // cmd[1:0], first[2]
   input  logic [23:0] req_tdata,   // base[7:0], position[17:8], zero fill
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // count[10:0], zero fill
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [10:0] csr_wdata
);

   localparam int HB         = 2 * KMER_SIZE;
   localparam int HEAD_DEPTH = 1 << HB;
   localparam int AW         = $clog2(MAX_SEQ_LEN);
   localparam int BW         = AW + 1;
   localparam int HW         = 2 + AW;
   localparam int LW         = 1 + AW;
   localparam int CLR_DEPTH  = (HEAD_DEPTH > MAX_SEQ_LEN) ? HEAD_DEPTH : MAX_SEQ_LEN;
   localparam int CW         = $clog2(CLR_DEPTH);
   localparam int CMP_W      = (AW > khdc_pkg::COUNT_W) ? AW + 1 : khdc_pkg::COUNT_W + 1;

   typedef enum logic [9:0] {
      ST_IDLE     = 10'b0000000001,
      ST_CLEAR    = 10'b0000000010,
      ST_STEP     = 10'b0000000100,
      ST_INS_HEAD = 10'b0000001000,
      ST_INS_TEST = 10'b0000010000,
      ST_INS_LINK = 10'b0000100000,
      ST_CNT_HEAD = 10'b0001000000,
      ST_WALK_RD  = 10'b0010000000,
      ST_WALK_WR  = 10'b0100000000,
      ST_RD_OUT   = 10'b1000000000
   } state_type;

   // configuration
   logic [khdc_pkg::WSTART_W-1:0] wstart_ff;
   logic [khdc_pkg::WEND_W-1:0]   wend_ff;
   logic [khdc_pkg::REPEAT_W-1:0] max_rep_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wstart_ff  <= khdc_pkg::WINDOW_START_RST;
         wend_ff    <= khdc_pkg::WINDOW_END_RST;
         max_rep_ff <= khdc_pkg::MAX_REPEAT_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            khdc_pkg::CSR_WINDOW_START: wstart_ff  <= csr_wdata[khdc_pkg::WSTART_W-1:0];
            khdc_pkg::CSR_WINDOW_END:   wend_ff    <= csr_wdata[khdc_pkg::WEND_W-1:0];
            khdc_pkg::CSR_MAX_REPEAT:   max_rep_ff <= csr_wdata[khdc_pkg::REPEAT_W-1:0];
            default: ;
         endcase
      end
   end

   // request fields
   logic [1:0]                  req_cmd;
   logic                        req_first;
   logic [khdc_pkg::BASE_W-1:0] req_base;
   logic [khdc_pkg::POS_W-1:0]  req_pos;
   logic                        req_acc;

   assign req_cmd   = req_tuser[1:0];
   assign req_first = req_tuser[2];
   assign req_base  = req_tdata[7:0];
   assign req_pos   = req_tdata[17:8];

   // state
   state_type                   state_ff, state_in;
   logic [1:0]                  cmd_ff, cmd_in;
   logic [1:0]                  code_ff, code_in;
   logic [khdc_pkg::POS_W-1:0]  pos_ff, pos_in;
   logic                        pend_ff, pend_in;
   logic [HB-1:0]               hash_ff, hash_in, hash_next;
   logic [BW-1:0]               bidx_ff, bidx_in;
   logic [AW-1:0]               w_ff, w_in;
   logic [AW-1:0]               ptr_ff, ptr_in;
   logic [khdc_pkg::SEEN_W-1:0] seen_ff, seen_in;
   logic [BW-1:0]               steps_ff, steps_in;
   logic                        hit_ff, hit_in;
   logic [AW-1:0]               p_ff, p_in;
   logic                        zero_ff, zero_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [khdc_pkg::COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   // memory ports
   logic          head_we;
   logic [HB-1:0] head_waddr, head_raddr;
   logic [HW-1:0] head_wdata, head_rdata;
   logic          link_we;
   logic [AW-1:0] link_waddr, link_raddr;
   logic [LW-1:0] link_wdata, link_rdata;
   logic          cnt_we;
   logic [AW-1:0] cnt_waddr, cnt_raddr;
   logic [khdc_pkg::COUNT_W-1:0] cnt_wdata, cnt_rdata;

   // FSM side of the write ports
   logic          fsm_head_we, fsm_link_we, fsm_cnt_we;
   logic [HW-1:0] fsm_head_wdata;
   logic [khdc_pkg::COUNT_W-1:0] fsm_cnt_wdata;

   // clearing sweep
   khdc_pkg::clr_sel_type clr_start, clr_sel;
   logic                  clr_busy;
   logic [CW-1:0]         clr_addr;

   khdc_clear #(.DEPTH(CLR_DEPTH)) u_clear (
      .clock (clock),
      .reset (reset),
      .start (clr_start),
      .busy  (clr_busy),
      .sel   (clr_sel),
      .addr  (clr_addr)
   );

   logic clr_head_we, clr_link_we, clr_cnt_we;
   assign clr_head_we = clr_busy && clr_sel.index &&
                        ({1'b0, clr_addr} < (CW+1)'(HEAD_DEPTH));
   assign clr_link_we = clr_busy && clr_sel.index &&
                        ({1'b0, clr_addr} < (CW+1)'(MAX_SEQ_LEN));
   assign clr_cnt_we  = clr_busy && clr_sel.counts &&
                        ({1'b0, clr_addr} < (CW+1)'(MAX_SEQ_LEN));

   assign head_we    = clr_head_we || fsm_head_we;
   assign head_waddr = clr_busy ? clr_addr[HB-1:0] : hash_ff;
   assign head_wdata = clr_busy ? {khdc_pkg::HEAD_EMPTY, {AW{1'b0}}} : fsm_head_wdata;
   assign link_we    = clr_link_we || fsm_link_we;
   assign link_waddr = clr_busy ? clr_addr[AW-1:0] : ptr_ff;
   assign link_wdata = clr_busy ? {1'b1, {AW{1'b0}}} : {1'b0, w_ff};
   assign cnt_we     = clr_cnt_we || fsm_cnt_we;
   assign cnt_waddr  = clr_busy ? clr_addr[AW-1:0] : p_ff;
   assign cnt_wdata  = clr_busy ? '0 : fsm_cnt_wdata;

   khdc_ram #(.WIDTH(HW), .DEPTH(HEAD_DEPTH)) u_head_ram (
      .clock(clock), .wr_en(head_we), .wr_addr(head_waddr), .wr_data(head_wdata),
      .rd_addr(head_raddr), .rd_data(head_rdata)
   );

   khdc_ram #(.WIDTH(LW), .DEPTH(MAX_SEQ_LEN)) u_link_ram (
      .clock(clock), .wr_en(link_we), .wr_addr(link_waddr), .wr_data(link_wdata),
      .rd_addr(link_raddr), .rd_data(link_rdata)
   );

   khdc_ram #(.WIDTH(khdc_pkg::COUNT_W), .DEPTH(MAX_SEQ_LEN)) u_cnt_ram (
      .clock(clock), .wr_en(cnt_we), .wr_addr(cnt_waddr), .wr_data(cnt_wdata),
      .rd_addr(cnt_raddr), .rd_data(cnt_rdata)
   );

   // head entry and link fields
   logic [1:0]    head_kind;
   logic [AW-1:0] head_ptr;
   logic          link_end;
   logic [AW-1:0] link_next;
   assign head_kind = head_rdata[HW-1:AW];
   assign head_ptr  = head_rdata[AW-1:0];
   assign link_end  = link_rdata[AW];
   assign link_next = link_rdata[AW-1:0];

   // diagonal of the current chain entry and its window check
   logic [AW-1:0]    diag;
   logic [CMP_W-1:0] diag_x;
   logic             diag_hit;
   assign diag     = ptr_ff - w_ff;
   assign diag_x   = CMP_W'(diag);
   assign diag_hit = (ptr_ff >= w_ff) && (diag_x >= CMP_W'(wstart_ff)) &&
                     (diag_x < CMP_W'(wend_ff));

   assign hash_next = {code_ff, hash_ff[HB-1:2]};
   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;

   // control
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      code_in      = code_ff;
      pos_in       = pos_ff;
      pend_in      = pend_ff;
      hash_in      = hash_ff;
      bidx_in      = bidx_ff;
      w_in         = w_ff;
      ptr_in       = ptr_ff;
      seen_in      = seen_ff;
      steps_in     = steps_ff;
      hit_in       = hit_ff;
      p_in         = p_ff;
      zero_in      = zero_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_count_in = rsp_count_ff;
      clr_start    = '{index: 1'b0, counts: 1'b0};
      fsm_head_we  = 1'b0;
      fsm_head_wdata = {khdc_pkg::HEAD_EMPTY, {AW{1'b0}}};
      fsm_link_we  = 1'b0;
      fsm_cnt_we   = 1'b0;
      fsm_cnt_wdata = cnt_rdata + khdc_pkg::COUNT_W'(1);
      head_raddr   = hash_next;
      link_raddr   = ptr_ff;
      cnt_raddr    = diag;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               cmd_in  = req_cmd;
               code_in = req_base[2:1];
               pos_in  = req_pos;
               unique case (req_cmd)
                  khdc_pkg::CMD_COUNT: begin
                     state_in = ST_RD_OUT;
                  end
                  khdc_pkg::CMD_REF, khdc_pkg::CMD_READ: begin
                     if (req_first) begin
                        clr_start.index  = (req_cmd == khdc_pkg::CMD_REF);
                        clr_start.counts = (req_cmd == khdc_pkg::CMD_READ);
                        hash_in  = '0;
                        bidx_in  = '0;
                        pend_in  = 1'b1;
                        state_in = ST_CLEAR;
                     end else begin
                        state_in = ST_STEP;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_CLEAR: begin
            if (!clr_busy) begin
               state_in = pend_ff ? ST_STEP : ST_IDLE;
               pend_in  = 1'b0;
            end
         end
         ST_STEP: begin
            if (bidx_ff >= BW'(MAX_SEQ_LEN)) begin
               state_in = ST_IDLE;
            end else begin
               hash_in = hash_next;
               bidx_in = bidx_ff + BW'(1);
               w_in    = AW'(bidx_ff - BW'(KMER_SIZE - 1));
               if (bidx_ff >= BW'(KMER_SIZE - 1)) begin
                  state_in = (cmd_ff == khdc_pkg::CMD_REF) ? ST_INS_HEAD : ST_CNT_HEAD;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_INS_HEAD: begin
            unique case (head_kind)
               khdc_pkg::HEAD_EMPTY: begin
                  fsm_head_we    = 1'b1;
                  fsm_head_wdata = {khdc_pkg::HEAD_START, w_ff};
                  state_in       = ST_IDLE;
               end
               khdc_pkg::HEAD_START: begin
                  ptr_in   = head_ptr;
                  seen_in  = khdc_pkg::SEEN_W'(2);
                  state_in = ST_INS_TEST;
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_INS_TEST: begin
            // too long: mark repetitive, else look at the next link
            if (seen_ff > khdc_pkg::SEEN_W'(max_rep_ff)) begin
               fsm_head_we    = 1'b1;
               fsm_head_wdata = {khdc_pkg::HEAD_REPEAT, {AW{1'b0}}};
               state_in       = ST_IDLE;
            end else begin
               state_in = ST_INS_LINK;
            end
         end
         ST_INS_LINK: begin
            if (link_end) begin
               fsm_link_we = 1'b1;
               state_in    = ST_IDLE;
            end else begin
               ptr_in   = link_next;
               seen_in  = seen_ff + khdc_pkg::SEEN_W'(1);
               state_in = ST_INS_TEST;
            end
         end
         ST_CNT_HEAD: begin
            if (head_kind == khdc_pkg::HEAD_START) begin
               ptr_in   = head_ptr;
               steps_in = '0;
               state_in = ST_WALK_RD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_WALK_RD: begin
            if (steps_ff >= BW'(MAX_SEQ_LEN)) begin
               state_in = ST_IDLE;
            end else begin
               hit_in   = diag_hit;
               p_in     = diag;
               state_in = ST_WALK_WR;
            end
         end
         ST_WALK_WR: begin
            // saturating increment of the hit bin
            fsm_cnt_we = hit_ff && (cnt_rdata != khdc_pkg::COUNT_MAX);
            steps_in   = steps_ff + BW'(1);
            ptr_in     = link_next;
            state_in   = link_end ? ST_IDLE : ST_WALK_RD;
         end
         ST_RD_OUT: begin
            // issue the read only once the response register is free
            cnt_raddr = AW'(pos_ff);
            if (!zero_ff && (!rsp_valid_ff || rsp_tready)) begin
               zero_in = 1'b1;
            end else if (zero_ff) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = (CMP_W'(pos_ff) >= CMP_W'(MAX_SEQ_LEN)) ? '0 : cnt_rdata;
               zero_in      = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         pend_ff      <= 1'b0;
         hash_ff      <= '0;
         bidx_ff      <= '0;
         zero_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         hash_ff      <= hash_in;
         bidx_ff      <= bidx_in;
         zero_ff      <= zero_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      code_ff      <= code_in;
      pos_ff       <= pos_in;
      w_ff         <= w_in;
      ptr_ff       <= ptr_in;
      seen_ff      <= seen_in;
      steps_ff     <= steps_in;
      hit_ff       <= hit_in;
      p_ff         <= p_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_count_ff};

endmodule

// ===== design/khdc_ram.sv =====
// Generic single-write, single-read memory with registered read data.
`timescale 1ns / 1ps

module khdc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== design/khdc_clear.sv =====
// Clearing sweep address generator: one entry per cycle, starts itself at reset.
`timescale 1ns / 1ps

module khdc_clear #(
   parameter int DEPTH = 65536
) (
   input  logic                      clock,
   input  logic                      reset,
   input  khdc_pkg::clr_sel_type     start,
   output logic                      busy,
   output khdc_pkg::clr_sel_type     sel,
   output logic [$clog2(DEPTH)-1:0]  addr
);

   localparam int AW = $clog2(DEPTH);
   localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

   logic                  active_ff;
   khdc_pkg::clr_sel_type sel_ff;
   logic [AW-1:0]         addr_ff;

   // sweep runs from address zero to the last entry of the largest memory
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b1;
         sel_ff    <= '{index: 1'b1, counts: 1'b1};
         addr_ff   <= '0;
      end else if (active_ff) begin
         if (addr_ff == LAST) begin
            active_ff <= 1'b0;
         end else begin
            addr_ff <= addr_ff + AW'(1);
         end
      end else if (start.index || start.counts) begin
         active_ff <= 1'b1;
         sel_ff    <= start;
         addr_ff   <= '0;
      end
   end

   assign busy = active_ff;
   assign sel  = sel_ff;
   assign addr = addr_ff;

endmodule

// ===== design/khdc_checker.sv =====
// Port-level checks of the k-mer index counter, bound to the top level.
`timescale 1ns / 1ps

module khdc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [2:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);

   // reset starts the clearing sweep with nothing pending at the output
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !req_tready && !rsp_tvalid)
      else $error("request or response open right after reset");

   // one request at a time: a real command closes the input
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && (req_tuser[1:0] != khdc_pkg::CMD_NONE)) |=> !req_tready)
      else $error("input still open after a request was taken");

   // a held response keeps its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response dropped or changed while stalled");

   // counts never exceed eleven bits
   a_rsp_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[15:11] == 5'b0))
      else $error("response fill bits not zero");

endmodule

bind kmer_hash_index_diagonal_counter khdc_checker u_khdc_checker (.*);

// ===== tb/tb.sv =====
// Self-checking bench for the k-mer index and per-diagonal hit counter.
`timescale 1ns / 1ps

module tb;

   localparam int KSIZE     = 8;
   localparam int SEQ_LEN   = 1024;
   localparam int HASH_SIZE = 1 << (2 * KSIZE);
   localparam int LIMIT     = 6000000;
   localparam int DRAIN     = 300;

   typedef struct {
      logic [1:0] cmd;
      logic       first;
      logic [7:0] base;
      logic [9:0] pos;
   } base_req_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [2:0]  req_tuser = '0;
   logic [23:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        csr_wr_en = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [10:0] csr_wdata = '0;

   kmer_hash_index_diagonal_counter uut (.*);

   // predictor state
   logic [1:0]  head_kind [HASH_SIZE];
   logic [10:0] head_pos [HASH_SIZE];
   bit          link_ok [SEQ_LEN];
   logic [10:0] link_next [SEQ_LEN];
   logic [10:0] diag_hits [SEQ_LEN];
   logic [15:0] kmer_hash;
   int          seq_idx;
   int          win_lo, win_hi, repeat_lim;

   base_req_type pending_req [$];
   logic [10:0]  expected_counts [$];
   int           errors = 0;
   int           cycles = 0;
   bit           quiet = 1'b0;

   initial begin
      forever #2 clock = ~clock;
   end

   task automatic clear_index();
      for (int i = 0; i < HASH_SIZE; i++) begin
         head_kind[i] = khdc_pkg::HEAD_EMPTY;
         head_pos[i] = '0;
      end
      for (int i = 0; i < SEQ_LEN; i++) begin
         link_ok[i] = 1'b0;
         link_next[i] = '0;
      end
   endtask

   task automatic clear_hits();
      for (int i = 0; i < SEQ_LEN; i++) diag_hits[i] = '0;
   endtask

   // append window start w to the chain of hash hv
   task automatic index_window(input int hv, input int w);
      int j;
      int seen;
      if (head_kind[hv] == khdc_pkg::HEAD_EMPTY) begin
         head_kind[hv] = khdc_pkg::HEAD_START;
         head_pos[hv] = 11'(w);
         return;
      end
      if (head_kind[hv] == khdc_pkg::HEAD_REPEAT) return;
      j = head_pos[hv];
      seen = 2;
      while (seen <= repeat_lim && j < SEQ_LEN && link_ok[j]) begin
         j = link_next[j];
         seen++;
      end
      if (seen > repeat_lim) head_kind[hv] = khdc_pkg::HEAD_REPEAT;
      else if (j < SEQ_LEN) begin
         link_ok[j] = 1'b1;
         link_next[j] = 11'(w);
      end
   endtask

   // walk the chain of hv and bump each diagonal bin in the window
   task automatic count_diagonals(input int hv, input int w);
      int h;
      int p;
      int steps;
      bit have;
      have = (head_kind[hv] == khdc_pkg::HEAD_START);
      h = head_pos[hv];
      steps = 0;
      while (have && steps < SEQ_LEN && h < SEQ_LEN) begin
         if (h >= w) begin
            p = h - w;
            if (p >= win_lo && p < win_hi && p < SEQ_LEN &&
                diag_hits[p] != khdc_pkg::COUNT_MAX)
               diag_hits[p] = diag_hits[p] + 11'd1;
         end
         have = link_ok[h];
         h = link_next[h];
         steps++;
      end
   endtask

   task automatic apply_request(input base_req_type r);
      if (r.cmd == khdc_pkg::CMD_COUNT) begin
         expected_counts = {expected_counts, diag_hits[r.pos]};
         return;
      end
      if (r.cmd == khdc_pkg::CMD_NONE) return;
      if (r.first) begin
         if (r.cmd == khdc_pkg::CMD_REF) clear_index();
         else clear_hits();
         kmer_hash = '0;
         seq_idx = 0;
      end
      if (seq_idx >= SEQ_LEN) return;
      kmer_hash = {r.base[2:1], kmer_hash[15:2]};
      if (seq_idx >= KSIZE - 1) begin
         if (r.cmd == khdc_pkg::CMD_REF) index_window(kmer_hash, seq_idx - (KSIZE - 1));
         else count_diagonals(kmer_hash, seq_idx - (KSIZE - 1));
      end
      seq_idx++;
   endtask

   // request driver
   base_req_type cur;
   int           req_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) apply_request(cur);
         if (!req_tvalid || req_tready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_req.size() > 0) begin
               cur = pending_req.pop_front();
               req_tvalid <= 1'b1;
               req_tuser <= {cur.first, cur.cmd};
               req_tdata <= {6'd0, cur.pos, cur.base};
               if (!quiet && $urandom_range(9, 0) == 0) req_gap = $urandom_range(18, 1);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response monitor with random back-pressure
   int rsp_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_counts.size() == 0) begin
               errors++;
               if (errors <= 10) $display("unexpected response count=%0d", rsp_tdata[10:0]);
            end else if (rsp_tdata[10:0] !== expected_counts[0]) begin
               errors++;
               if (errors <= 10)
                  $display("count mismatch: expected %0d actual %0d",
                           expected_counts[0], rsp_tdata[10:0]);
               void'(expected_counts.pop_front());
            end else begin
               void'(expected_counts.pop_front());
            end
         end
         if (quiet) rsp_tready <= 1'b1;
         else if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_tready <= 1'b0;
         end else if ($urandom_range(7, 0) == 0) begin
            rsp_gap = $urandom_range(18, 1);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   task automatic push_req(input logic [1:0] cmd, input bit first, input int code,
                           input int pos);
      base_req_type r;
      r.cmd = cmd;
      r.first = first;
      r.base = 8'(($urandom() & 32'hF9) | (code[1:0] << 1));
      r.pos = 10'(pos);
      pending_req = {pending_req, r};
   endtask

   task automatic wait_idle();
      while (pending_req.size() != 0 || req_tvalid || expected_counts.size() != 0)
         @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input int val);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= 11'(val);
      if (idx == khdc_pkg::CSR_WINDOW_START) win_lo = val & 10'h3FF;
      else if (idx == khdc_pkg::CSR_WINDOW_END) win_hi = val & 11'h7FF;
      else repeat_lim = val & 7'h7F;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic set_config(input int lo, input int hi, input int rep);
      csr_write(khdc_pkg::CSR_WINDOW_START, lo);
      csr_write(khdc_pkg::CSR_WINDOW_END, hi);
      csr_write(khdc_pkg::CSR_MAX_REPEAT, rep);
   endtask

   // reference with planted repeats and a low-complexity run, then related reads
   task automatic random_phase(input int ref_len);
      int ref_codes [$];
      int offs [$];
      int src, seg, o, len, n;
      ref_codes.delete();
      while (ref_codes.size() < ref_len) begin
         n = $urandom_range(9, 0);
         if (n < 2 && ref_codes.size() > 12) begin
            src = $urandom_range(ref_codes.size() - 10, 0);
            seg = $urandom_range(10, 8);
            for (int i = 0; i < seg; i++) ref_codes = {ref_codes, ref_codes[src + i]};
         end else if (n == 2) begin
            seg = $urandom_range(14, 8);
            src = $urandom_range(3, 0);
            for (int i = 0; i < seg; i++) ref_codes = {ref_codes, src};
         end else begin
            ref_codes = {ref_codes, int'($urandom_range(3, 0))};
         end
      end
      for (int i = 0; i < ref_codes.size(); i++)
         push_req(khdc_pkg::CMD_REF, i == 0, ref_codes[i], $urandom_range(1023, 0));
      for (int r = 0; r < 2; r++) begin
         len = $urandom_range(40, 16);
         o = $urandom_range(ref_codes.size() - len, 0);
         offs = {offs, o};
         for (int i = 0; i < len; i++)
            push_req(khdc_pkg::CMD_READ, (i == 0) && (r == 0 || $urandom_range(1, 0)),
                     ($urandom_range(19, 0) == 0) ? $urandom_range(3, 0)
                                                  : ref_codes[o + i],
                     $urandom_range(1023, 0));
      end
      foreach (offs[i]) begin
         push_req(khdc_pkg::CMD_COUNT, $urandom_range(1, 0), 0, offs[i]);
         push_req(khdc_pkg::CMD_COUNT, $urandom_range(1, 0), 0, offs[i] + 1);
      end
      for (int i = 0; i < 6; i++) begin
         if ($urandom_range(3, 0) == 0)
            push_req(khdc_pkg::CMD_NONE, $urandom_range(1, 0), 0, 0);
         push_req(khdc_pkg::CMD_COUNT, $urandom_range(1, 0), 0,
                  $urandom_range(1, 0) ? $urandom_range(1023, 0) : $urandom_range(60, 0));
      end
   endtask

   initial begin
      clear_index();
      clear_hits();
      kmer_hash = '0;
      seq_idx = 0;
      win_lo = 0;
      win_hi = 1024;
      repeat_lim = 8;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: repetitive chain with a limit of 2, readout edges, unused code
      set_config(0, 1024, 2);
      for (int i = 0; i < 12; i++) push_req(khdc_pkg::CMD_REF, i == 0, 0, 0);
      for (int i = 0; i < 9; i++) push_req(khdc_pkg::CMD_READ, i == 0, 0, 1023);
      push_req(khdc_pkg::CMD_REF, 1'b0, 3, 0);      // mixed kinds share the base counter
      push_req(khdc_pkg::CMD_NONE, 1'b1, 2, 5);
      push_req(khdc_pkg::CMD_COUNT, 1'b1, 0, 0);
      push_req(khdc_pkg::CMD_COUNT, 1'b0, 0, 1023);
      wait_idle();

      // random phases across window and repeat settings, extremes included
      set_config(1023, 0, 64);
      random_phase(60);
      wait_idle();
      set_config(0, 1024, 64);
      random_phase(90);
      wait_idle();
      set_config($urandom_range(10, 0), $urandom_range(80, 20), $urandom_range(64, 2));
      random_phase(70);
      wait_idle();
      set_config(0, 1024, 3);
      random_phase(60);
      wait_idle();

      // longer reference sequence, then reads of it with no idling
      set_config(0, 1024, 8);
      quiet = 1'b1;
      random_phase(150);
      wait_idle();

      repeat (DRAIN) @(posedge clock);
      if (errors == 0 && expected_counts.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
